@@ src/ccs_pkg.sv @@
// Shared types, constants and month length helper for the calendar clock.
`timescale 1ns / 1ps

package ccs_pkg;

    localparam logic [6:0] YearMin       = 7'd19;
    localparam logic [6:0] YearMax       = 7'd82;
    localparam logic [3:0] MonthsPerYear = 4'd12;
    localparam logic [4:0] HoursPerDay   = 5'd24;
    localparam logic [5:0] MinPerHour    = 6'd60;
    localparam logic [5:0] SecPerMin     = 6'd60;
    localparam logic [4:0] LeapDays      = 5'd29;
    localparam logic [4:0] MaxDays       = 5'd31;
    localparam logic [1:0] LeapMask      = 2'b11;

    localparam int StampYearShift   = 4 + 5 + 5 + 6 + 6;
    localparam int StampMonthShift  = 5 + 5 + 6 + 6;
    localparam int StampDayShift    = 5 + 6 + 6;
    localparam int StampHourShift   = 6 + 6;
    localparam int StampMinuteShift = 6;

    localparam logic [4:0] DaysInMonth [0:11] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef enum logic {
        MODE_TICK = 1'b0,
        MODE_SET  = 1'b1
    } mode_t;

    typedef struct packed {
        logic [6:0] year;
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } cal_time_t;

    typedef struct packed {
        mode_t     mode;
        cal_time_t set_time;
    } item_t;

    typedef struct packed {
        cal_time_t cal;
        logic      accepted;
    } step_res_t;

    // Months outside 1..12 count as 31 days so every compare stays total.
    function automatic logic [4:0] month_len(input logic [6:0] year, input logic [3:0] month);
        logic [4:0] len;
        begin
            len = MaxDays;
            if (month >= 4'd1 && month <= MonthsPerYear)
            begin
                len = DaysInMonth[month - 4'd1];
                if (month == 4'd2 && (year[1:0] & LeapMask) == 2'b00)
                begin
                    len = LeapDays;
                end
            end
            return len;
        end
    endfunction

endpackage

@@ src/ccs_step.sv @@
// Next-state logic: one-second advance with carries, or validated load.
`timescale 1ns / 1ps

module ccs_step (
    input  ccs_pkg::cal_time_t cur,
    input  ccs_pkg::item_t     item,
    output ccs_pkg::step_res_t res
);

    logic [6:0]         sec_inc;
    logic [6:0]         min_inc;
    logic [5:0]         hour_inc;
    logic [5:0]         day_inc;
    logic [4:0]         month_inc;
    logic [7:0]         year_inc;
    logic [4:0]         cur_len;
    logic [4:0]         set_len;
    logic               set_ok;
    ccs_pkg::cal_time_t tick;

    assign sec_inc   = {1'b0, cur.second} + 7'd1;
    assign min_inc   = {1'b0, cur.minute} + 7'd1;
    assign hour_inc  = {1'b0, cur.hour} + 6'd1;
    assign day_inc   = {1'b0, cur.day} + 6'd1;
    assign month_inc = {1'b0, cur.month} + 5'd1;
    assign year_inc  = {1'b0, cur.year} + 8'd1;
    assign cur_len   = ccs_pkg::month_len(cur.year, cur.month);
    assign set_len   = ccs_pkg::month_len(item.set_time.year, item.set_time.month);

    always_comb
    begin
        tick = cur;
        if (sec_inc < {1'b0, ccs_pkg::SecPerMin})
        begin
            tick.second = sec_inc[5:0];
        end
        else
        begin
            tick.second = 6'd0;
            if (min_inc < {1'b0, ccs_pkg::MinPerHour})
            begin
                tick.minute = min_inc[5:0];
            end
            else
            begin
                tick.minute = 6'd0;
                if (hour_inc < {1'b0, ccs_pkg::HoursPerDay})
                begin
                    tick.hour = hour_inc[4:0];
                end
                else
                begin
                    tick.hour = 5'd0;
                    if (day_inc <= {1'b0, cur_len})
                    begin
                        tick.day = day_inc[4:0];
                    end
                    else
                    begin
                        tick.day = 5'd1;
                        if (month_inc <= {1'b0, ccs_pkg::MonthsPerYear})
                        begin
                            tick.month = month_inc[3:0];
                        end
                        else
                        begin
                            tick.month = 4'd1;
                            if (year_inc > {1'b0, ccs_pkg::YearMax})
                            begin
                                tick.year = ccs_pkg::YearMin;
                            end
                            else
                            begin
                                tick.year = year_inc[6:0];
                            end
                        end
                    end
                end
            end
        end
    end

    assign set_ok = item.set_time.year >= ccs_pkg::YearMin
                 && item.set_time.year <= ccs_pkg::YearMax
                 && item.set_time.month >= 4'd1
                 && item.set_time.month <= ccs_pkg::MonthsPerYear
                 && item.set_time.day >= 5'd1
                 && item.set_time.day <= set_len
                 && item.set_time.hour < ccs_pkg::HoursPerDay
                 && item.set_time.minute < ccs_pkg::MinPerHour
                 && item.set_time.second < ccs_pkg::SecPerMin;

    always_comb
    begin
        res.accepted = 1'b0;
        case (item.mode)
            ccs_pkg::MODE_TICK:
            begin
                res.cal = tick;
            end
            ccs_pkg::MODE_SET:
            begin
                res.cal      = set_ok ? item.set_time : cur;
                res.accepted = set_ok;
            end
            default:
            begin
                res.cal = cur;
            end
        endcase
    end

endmodule

@@ src/calendar_clock_with_set_and_pack.sv @@
// Top level: input register, calendar state, result register and stamp packing.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_stall  | mode, set_year .. set_second
//  out     | out_valid/ out_stall | cur_year .. cur_second, packed_stamp,
//          |                      | set_accepted
//
// One transaction per cycle while out_stall is low; a result is valid after passing
// two register stages (input register, then the step logic into the result register).
// The one-second carry chain and set validation sit between those two registers.
// Reset (rst_n low) loads 2019-06-06 08:47:56 and empties both registers.
// A stalled result holds; in_stall rises only when both registers are full and
// the result is stalled.
`timescale 1ns / 1ps

module calendar_clock_with_set_and_pack (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [6:0]  set_year,
    input  logic [3:0]  set_month,
    input  logic [4:0]  set_day,
    input  logic [4:0]  set_hour,
    input  logic [5:0]  set_minute,
    input  logic [5:0]  set_second,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [6:0]  cur_year,
    output logic [3:0]  cur_month,
    output logic [4:0]  cur_day,
    output logic [4:0]  cur_hour,
    output logic [5:0]  cur_minute,
    output logic [5:0]  cur_second,
    output logic [31:0] packed_stamp,
    output logic        set_accepted
);

    localparam ccs_pkg::cal_time_t ResetTime = '{
        year: 7'd19, month: 4'd6, day: 5'd6, hour: 5'd8, minute: 6'd47, second: 6'd56
    };

    logic               s1_valid_reg;
    logic               s1_valid_next;
    ccs_pkg::item_t     s1_item_reg;
    ccs_pkg::cal_time_t state_reg;
    ccs_pkg::cal_time_t state_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    ccs_pkg::step_res_t out_res_reg;
    ccs_pkg::step_res_t step_res;
    ccs_pkg::item_t     in_item;
    logic               in_take;
    logic               s1_adv;
    logic [6:0]         year_ofs;

    assign in_item.mode                = ccs_pkg::mode_t'(mode);
    assign in_item.set_time.year       = set_year;
    assign in_item.set_time.month      = set_month;
    assign in_item.set_time.day        = set_day;
    assign in_item.set_time.hour       = set_hour;
    assign in_item.set_time.minute     = set_minute;
    assign in_item.set_time.second     = set_second;

    // The held item moves on when the result slot is empty or being drained.
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_adv;
    assign in_take  = in_valid && !in_stall;

    ccs_step u_step (
        .cur  (state_reg),
        .item (s1_item_reg),
        .res  (step_res)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign state_next = s1_adv ? step_res.cal : state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= ResetTime;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_item_reg <= in_item;
        end
        if (s1_adv)
        begin
            out_res_reg <= step_res;
        end
    end

    assign year_ofs = out_res_reg.cal.year - ccs_pkg::YearMin;

    assign out_valid    = out_valid_reg;
    assign cur_year     = out_res_reg.cal.year;
    assign cur_month    = out_res_reg.cal.month;
    assign cur_day      = out_res_reg.cal.day;
    assign cur_hour     = out_res_reg.cal.hour;
    assign cur_minute   = out_res_reg.cal.minute;
    assign cur_second   = out_res_reg.cal.second;
    assign set_accepted = out_res_reg.accepted;
    assign packed_stamp = (32'(year_ofs[5:0]) << ccs_pkg::StampYearShift)
                        | (32'(out_res_reg.cal.month) << ccs_pkg::StampMonthShift)
                        | (32'(out_res_reg.cal.day) << ccs_pkg::StampDayShift)
                        | (32'(out_res_reg.cal.hour) << ccs_pkg::StampHourShift)
                        | (32'(out_res_reg.cal.minute) << ccs_pkg::StampMinuteShift)
                        | 32'(out_res_reg.cal.second);

`ifndef SYNTHESIS
    // The stored clock never leaves its legal ranges.
    a_state_legal: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.year >= ccs_pkg::YearMin && state_reg.year <= ccs_pkg::YearMax
        && state_reg.month >= 4'd1 && state_reg.month <= ccs_pkg::MonthsPerYear
        && state_reg.day >= 5'd1
        && state_reg.day <= ccs_pkg::month_len(state_reg.year, state_reg.month)
        && state_reg.hour < ccs_pkg::HoursPerDay
        && state_reg.minute < ccs_pkg::MinPerHour
        && state_reg.second < ccs_pkg::SecPerMin)
        else $error("calendar state out of range");

    // Input backpressure only when both stages hold a transaction.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled with a free stage");

    // A tick always moves the clock, so its result differs from the prior state.
    a_tick_moves: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && s1_item_reg.mode == ccs_pkg::MODE_TICK |=> state_reg != $past(state_reg))
        else $error("tick left the clock unchanged");

    // A stored result matches the clock state right after its update.
    a_result_state: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> out_res_reg.cal == state_reg)
        else $error("result does not match clock state");
`endif

endmodule

@@ dv/tb_calendar_clock_with_set_and_pack.sv @@
// Self-checking testbench for the calendar clock: tick and set traffic against a local predictor.
`timescale 1ns / 1ps

module tb_calendar_clock_with_set_and_pack;

    import ccs_pkg::*;

    localparam int WatchdogLimit = 2000;
    localparam int MaxReported   = 10;
    localparam int HoldOffCycles = 150;

    typedef struct {
        cal_time_t  cal;
        logic [31:0] stamp;
        logic        accepted;
    } reading_t;

    // Tracks the calendar as the block should see it and holds the readings still owed.
    class clock_tracker;
        cal_time_t clock_now;
        reading_t  owed_readings[$];
        int        mismatches;
        int        compared;
        int        ticks;
        int        loaded_sets;
        int        refused_sets;
        int        year_wraps;

        function new();
            clock_now.year   = 7'd19;
            clock_now.month  = 4'd6;
            clock_now.day    = 5'd6;
            clock_now.hour   = 5'd8;
            clock_now.minute = 6'd47;
            clock_now.second = 6'd56;
            mismatches   = 0;
            compared     = 0;
            ticks        = 0;
            loaded_sets  = 0;
            refused_sets = 0;
            year_wraps   = 0;
        endfunction

        function logic [4:0] days_in(logic [6:0] yr, logic [3:0] mo);
            logic [4:0] len;
            case (mo)
                4'd2:                      len = (yr[1:0] == 2'b00) ? 5'd29 : 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
                default:                   len = 5'd31;
            endcase
            return len;
        endfunction

        function logic [31:0] stamp_of(cal_time_t c);
            logic [6:0] yoff;
            yoff = c.year - YearMin;
            return {yoff[5:0], c.month, c.day, c.hour, c.minute, c.second};
        endfunction

        function void advance_one_second();
            if (clock_now.second < SecPerMin - 6'd1)
            begin
                clock_now.second = clock_now.second + 6'd1;
                return;
            end
            clock_now.second = 6'd0;
            if (clock_now.minute < MinPerHour - 6'd1)
            begin
                clock_now.minute = clock_now.minute + 6'd1;
                return;
            end
            clock_now.minute = 6'd0;
            if (clock_now.hour < HoursPerDay - 5'd1)
            begin
                clock_now.hour = clock_now.hour + 5'd1;
                return;
            end
            clock_now.hour = 5'd0;
            if (clock_now.day < days_in(clock_now.year, clock_now.month))
            begin
                clock_now.day = clock_now.day + 5'd1;
                return;
            end
            clock_now.day = 5'd1;
            if (clock_now.month < MonthsPerYear)
            begin
                clock_now.month = clock_now.month + 4'd1;
                return;
            end
            clock_now.month = 4'd1;
            if (clock_now.year >= YearMax)
            begin
                clock_now.year = YearMin;
                year_wraps++;
            end
            else
            begin
                clock_now.year = clock_now.year + 7'd1;
            end
        endfunction

        function void note_item(mode_t m, cal_time_t req);
            reading_t owed;
            logic     ok;
            owed.accepted = 1'b0;
            if (m == MODE_TICK)
            begin
                advance_one_second();
                ticks++;
            end
            else
            begin
                ok = req.year >= YearMin && req.year <= YearMax &&
                     req.month >= 4'd1 && req.month <= MonthsPerYear &&
                     req.day >= 5'd1 && req.day <= days_in(req.year, req.month) &&
                     req.hour < HoursPerDay && req.minute < MinPerHour &&
                     req.second < SecPerMin;
                if (ok)
                begin
                    clock_now     = req;
                    owed.accepted = 1'b1;
                    loaded_sets++;
                end
                else
                begin
                    refused_sets++;
                end
            end
            owed.cal   = clock_now;
            owed.stamp = stamp_of(clock_now);
            owed_readings.push_back(owed);
        endfunction

        function void check_reading(cal_time_t cal, logic [31:0] stamp, logic acc);
            reading_t owed;
            if (owed_readings.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MaxReported)
                    $display("[%0t] unexpected result %0d-%0d-%0d %0d:%0d:%0d stamp %h acc %b",
                             $realtime, cal.year, cal.month, cal.day, cal.hour, cal.minute,
                             cal.second, stamp, acc);
                return;
            end
            owed = owed_readings.pop_front();
            compared++;
            if (cal.year !== owed.cal.year || cal.month !== owed.cal.month ||
                cal.day !== owed.cal.day || cal.hour !== owed.cal.hour ||
                cal.minute !== owed.cal.minute || cal.second !== owed.cal.second ||
                stamp !== owed.stamp || acc !== owed.accepted)
            begin
                mismatches++;
                if (mismatches <= MaxReported)
                begin
                    $display("[%0t] mismatch: exp %0d-%0d-%0d %0d:%0d:%0d stamp %h acc %b",
                             $realtime, owed.cal.year, owed.cal.month, owed.cal.day,
                             owed.cal.hour, owed.cal.minute, owed.cal.second, owed.stamp,
                             owed.accepted);
                    $display("          got %0d-%0d-%0d %0d:%0d:%0d stamp %h acc %b",
                             cal.year, cal.month, cal.day, cal.hour, cal.minute, cal.second,
                             stamp, acc);
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        mode;
    logic [6:0]  set_year;
    logic [3:0]  set_month;
    logic [4:0]  set_day;
    logic [4:0]  set_hour;
    logic [5:0]  set_minute;
    logic [5:0]  set_second;
    logic        out_valid;
    logic        out_stall;
    logic [6:0]  cur_year;
    logic [3:0]  cur_month;
    logic [4:0]  cur_day;
    logic [4:0]  cur_hour;
    logic [5:0]  cur_minute;
    logic [5:0]  cur_second;
    logic [31:0] packed_stamp;
    logic        set_accepted;

    clock_tracker tracker;
    int           send_idle_pct;
    int           stall_pct;
    int           hold_left;
    int           quiet_cycles;

    calendar_clock_with_set_and_pack u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .set_year     (set_year),
        .set_month    (set_month),
        .set_day      (set_day),
        .set_hour     (set_hour),
        .set_minute   (set_minute),
        .set_second   (set_second),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .cur_year     (cur_year),
        .cur_month    (cur_month),
        .cur_day      (cur_day),
        .cur_hour     (cur_hour),
        .cur_minute   (cur_minute),
        .cur_second   (cur_second),
        .packed_stamp (packed_stamp),
        .set_accepted (set_accepted)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side: random stall, or a counted hold-off when one is requested.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_reading('{cur_year, cur_month, cur_day, cur_hour, cur_minute,
                                    cur_second}, packed_stamp, set_accepted);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WatchdogLimit)
            begin
                $display("Watchdog: no transaction for %0d cycles", quiet_cycles);
                $display("FAILURE");
                $finish;
            end
        end
    end

    function automatic cal_time_t make_time(int y, int mo, int d, int h, int mi, int s);
        cal_time_t t;
        t.year   = y[6:0];
        t.month  = mo[3:0];
        t.day    = d[4:0];
        t.hour   = h[4:0];
        t.minute = mi[5:0];
        t.second = s[5:0];
        return t;
    endfunction

    function automatic cal_time_t raw_fields();
        return make_time($urandom_range(127), $urandom_range(15), $urandom_range(31),
                         $urandom_range(31), $urandom_range(63), $urandom_range(63));
    endfunction

    function automatic int month_days(int y, int mo);
        if (mo == 2)
            return (y % 4 == 0) ? 29 : 28;
        if (mo == 4 || mo == 6 || mo == 9 || mo == 11)
            return 30;
        return 31;
    endfunction

    function automatic cal_time_t any_valid_set();
        int y;
        int mo;
        y  = $urandom_range(82, 19);
        mo = $urandom_range(12, 1);
        return make_time(y, mo, $urandom_range(month_days(y, mo), 1), $urandom_range(23),
                         $urandom_range(59), $urandom_range(59));
    endfunction

    // Valid time a few ticks short of a carry, biased toward month and year ends.
    function automatic cal_time_t near_rollover();
        int y;
        int mo;
        int d;
        y  = ($urandom_range(3) == 0) ? 82 : $urandom_range(82, 19);
        mo = ($urandom_range(2) == 0) ? 12 : $urandom_range(12, 1);
        d  = ($urandom_range(2) != 0) ? month_days(y, mo) : $urandom_range(month_days(y, mo), 1);
        return make_time(y, mo, d, ($urandom_range(2) != 0) ? 23 : $urandom_range(23),
                         ($urandom_range(2) != 0) ? 59 : $urandom_range(59),
                         $urandom_range(59, 50));
    endfunction

    // Valid set with exactly one field pushed out of range.
    function automatic cal_time_t broken_set();
        cal_time_t t;
        int        len;
        t   = any_valid_set();
        len = month_days(t.year, t.month);
        case ($urandom_range(5))
            0: t.year  = 7'(($urandom_range(1) != 0) ? $urandom_range(18)
                                                     : $urandom_range(127, 83));
            1: t.month = ($urandom_range(1) != 0) ? 4'd0 : 4'($urandom_range(15, 13));
            2: t.day   = (len < 31 && $urandom_range(1) != 0)
                       ? 5'($urandom_range(31, len + 1)) : 5'd0;
            3: t.hour  = 5'($urandom_range(31, 24));
            4: t.minute = 6'($urandom_range(63, 60));
            default: t.second = 6'($urandom_range(63, 60));
        endcase
        return t;
    endfunction

    task automatic send_item(input mode_t m, input cal_time_t t);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= m;
        set_year   <= t.year;
        set_month  <= t.month;
        set_day    <= t.day;
        set_hour   <= t.hour;
        set_minute <= t.minute;
        set_second <= t.second;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.note_item(m, t);
    endtask

    task automatic send_tick();
        send_item(MODE_TICK, raw_fields());
    endtask

    task automatic wait_all_results();
        in_valid <= 1'b0;
        while (tracker.owed_readings.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_random(input int count);
        int sent;
        int pick;
        int run;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(99);
            if (pick < 18)
            begin
                send_item(MODE_SET, near_rollover());
                run = $urandom_range(12, 1);
                repeat (run) send_tick();
                sent += run + 1;
            end
            else
            begin
                if (pick < 26)
                    send_item(MODE_SET, raw_fields());
                else if (pick < 36)
                    send_item(MODE_SET, broken_set());
                else if (pick < 44)
                    send_item(MODE_SET, any_valid_set());
                else
                    send_tick();
                sent++;
            end
        end
    endtask

    initial
    begin
        tracker       = new();
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_left     = 0;
        quiet_cycles  = 0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        mode          = MODE_TICK;
        set_year      = '0;
        set_month     = '0;
        set_day       = '0;
        set_hour      = '0;
        set_minute    = '0;
        set_second    = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset value, extremes, every rejection reason, carries and leap days.
        send_item(MODE_TICK, make_time(127, 15, 31, 31, 63, 63));
        send_item(MODE_SET, make_time(82, 12, 31, 23, 59, 59));
        send_tick();
        send_item(MODE_SET, make_time(18, 5, 10, 10, 10, 10));
        send_item(MODE_SET, make_time(83, 5, 10, 10, 10, 10));
        send_item(MODE_SET, make_time(127, 15, 31, 31, 63, 63));
        send_item(MODE_SET, make_time(0, 0, 0, 0, 0, 0));
        send_item(MODE_SET, make_time(30, 0, 10, 10, 10, 10));
        send_item(MODE_SET, make_time(30, 13, 10, 10, 10, 10));
        send_item(MODE_SET, make_time(30, 5, 0, 10, 10, 10));
        send_item(MODE_SET, make_time(30, 4, 31, 10, 10, 10));
        send_item(MODE_SET, make_time(21, 2, 29, 10, 10, 10));
        send_item(MODE_SET, make_time(30, 5, 10, 24, 10, 10));
        send_item(MODE_SET, make_time(30, 5, 10, 10, 60, 10));
        send_item(MODE_SET, make_time(30, 5, 10, 10, 10, 60));
        send_item(MODE_SET, make_time(20, 2, 29, 23, 59, 59));
        send_tick();
        send_item(MODE_SET, make_time(21, 2, 28, 23, 59, 59));
        send_tick();
        send_item(MODE_SET, make_time(44, 4, 30, 23, 59, 59));
        send_tick();
        send_item(MODE_SET, make_time(19, 1, 1, 0, 0, 0));
        send_item(MODE_TICK, make_time(0, 0, 0, 0, 0, 0));

        // Hold the result side while items keep coming so the input backs up.
        hold_left = HoldOffCycles;
        repeat (20) send_tick();
        wait_all_results();

        run_random(400);
        wait_all_results();

        send_idle_pct = 86;
        run_random(350);
        wait_all_results();

        send_idle_pct = 0;
        stall_pct     = 86;
        run_random(350);
        wait_all_results();

        send_idle_pct = 12;
        stall_pct     = 12;
        run_random(350);
        wait_all_results();

        stall_pct = 0;
        repeat (8) @(posedge clk);

        $display("Covered %0d ticks, %0d loaded sets, %0d refused sets, %0d year wraps",
                 tracker.ticks, tracker.loaded_sets, tracker.refused_sets, tracker.year_wraps);
        $display("%0d results compared, %0d mismatches, %0d still owed",
                 tracker.compared, tracker.mismatches, tracker.owed_readings.size());
        if (tracker.mismatches == 0 && tracker.owed_readings.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ files.f @@
src/ccs_pkg.sv
src/ccs_step.sv
src/calendar_clock_with_set_and_pack.sv
dv/tb_calendar_clock_with_set_and_pack.sv
